/* src/dau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_pkg: shared widths, types and arctangent constants
// Fixed datapath widths of the dihedral angle pipeline.
// ----------------------------------------------------------------------------
package dau_pkg;

   localparam int COORD_W      = 32;
   localparam int NUM_COORDS   = 12;
   localparam int B_W          = COORD_W + 1;      // bond vector component
   localparam int PROD_W       = 2 * B_W;          // cross product term
   localparam int CROSS_W      = PROD_W + 1;       // normal component
   localparam int MAG_W        = CROSS_W;
   localparam int CHUNKS       = (MAG_W + 7) / 8;
   localparam int LEN_W        = 7;
   localparam int UNIT_BITS    = 30;
   localparam int SM_W         = UNIT_BITS;
   localparam int WIDE_W       = MAG_W + UNIT_BITS;
   localparam int SQ_W         = 2 * SM_W;
   localparam int ROOT_W       = 62;
   localparam int SQRT_STEPS   = 31;
   localparam int QUO_W        = 31;
   localparam int DIV_STEPS    = QUO_W;
   localparam int DREM_W       = 32;
   localparam int U_W          = 32;
   localparam int DOTP_W       = 64;
   localparam int C_W          = 32;
   localparam int CORDIC_STEPS = 32;
   localparam int XY_W         = 34;
   localparam int Z_W          = 64;

   typedef logic signed [U_W-1:0] unit_type;

   typedef struct packed {
      logic           valid;
      logic           zero;
      unit_type [2:0] u;
   } unit_out_type;

   // Long division, evaluated at elaboration only (table build).
   function automatic logic [63:0] cf_div(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[63:0], num[k]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[k] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/n) in Q.62 by truncated Taylor series.
   function automatic logic [63:0] series_atan_inv(input logic [63:0] n);
      logic [63:0] p;
      logic [63:0] n2;
      logic [63:0] sum;
      logic [63:0] term;
      p   = cf_div(64'd1 << 62, n);
      n2  = n * n;
      sum = '0;
      for (int k = 0; k < 40; k++) begin
         term = cf_div(p, 64'(2 * k + 1));
         if (k % 2 == 1) sum = sum - term;
         else            sum = sum + term;
         p = cf_div(p, n2);
      end
      return sum;
   endfunction

   localparam logic [63:0] QUARTER_PI62 = 64'd4 * series_atan_inv(64'd5)
                                        - series_atan_inv(64'd239);
   localparam logic [63:0] HALF_PI60    = (64'd2 * QUARTER_PI62 + 64'd2) >> 2;

   // atan(2^-i) in Q.60, rounded half up from Q.62.
   function automatic logic [63:0] atan_q60(input int i);
      if (i == 0) return (QUARTER_PI62 + 64'd2) >> 2;
      return (series_atan_inv(64'd1 << i) + 64'd2) >> 2;
   endfunction

endpackage

/* src/dihedral_angle_unit_top.sv */
`timescale 1ns / 1ps
// Throughput: one quadruple per cycle while the skid slot is empty; every
//   stage is a register cell and the root, divide and CORDIC loops are
//   unrolled into chains of such cells.
// A stalled rsp side fills the output skid slot, then req_tready drops.
// Reset: synchronous, active high; clears all valid bits, no data flushed.
// ----------------------------------------------------------------------------
// dihedral_angle_unit_top: torsion angle between the planes of four atoms
// Bond vectors, plane normals, unit normals, cosine, and acos by CORDIC.
// ----------------------------------------------------------------------------
module dihedral_angle_unit_top #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // first_x, first_y, first_z, second_x .. fourth_z, 32 bits each, from bit 0
   input  logic [dau_pkg::NUM_COORDS*dau_pkg::COORD_W-1:0] req_tdata,
   input  logic                                             req_tvalid,
   output logic                                             req_tready,
   // angle (ANGLE_FRAC_BITS+2 bits, Q2 radians) from bit 0, zero padded
   output logic [((ANGLE_FRAC_BITS + 2 + 7) / 8) * 8-1:0]   rsp_tdata,
   // degenerate
   output logic                                             rsp_tuser,
   output logic                                             rsp_tvalid,
   input  logic                                             rsp_tready
);
   import dau_pkg::*;

   localparam int ANGLE_W  = ANGLE_FRAC_BITS + 2;
   localparam int RSP_W    = ((ANGLE_W + 7) / 8) * 8;
   localparam int SHIFT    = 60 - ANGLE_FRAC_BITS;
   localparam logic [63:0] PI60  = 64'd2 * HALF_PI60;
   localparam logic [63:0] HALF  = 64'd1 << (SHIFT - 1);
   localparam logic [63:0] AMAX  = (PI60 + HALF) >> SHIFT;
   localparam int CTAG_W   = C_W + 1;
   // 1.0 in Q.30, signed so the cosine clamp compares signed
   localparam logic signed [DOTP_W-1:0] C_LIM = DOTP_W'(64'd1 << UNIT_BITS);

   // Global advance: the whole pipe moves unless the skid slot is occupied.
   logic ce;
   logic skid_v_ff;

   assign ce         = ~skid_v_ff;
   assign req_tready = ce;

   // ---------------------------------------------------------------- bonds
   logic signed [COORD_W-1:0] r [NUM_COORDS];
   logic signed [B_W-1:0]     b1_in [3], b2_in [3], b3_in [3];
   logic signed [B_W-1:0]     b1_ff [3], b2_ff [3], b3_ff [3];
   logic                      t1_valid_ff;

   always_comb begin
      for (int i = 0; i < NUM_COORDS; i++) r[i] = req_tdata[COORD_W*i +: COORD_W];
      for (int i = 0; i < 3; i++) begin
         b1_in[i] = B_W'(r[3+i]) - B_W'(r[i]);
         b2_in[i] = B_W'(r[6+i]) - B_W'(r[3+i]);
         b3_in[i] = B_W'(r[9+i]) - B_W'(r[6+i]);
      end
   end

   // ---------------------------------------------------- cross products
   // pa[k] - pb[k] gives component k of n1 (k < 3) or n2 (k >= 3)
   logic signed [PROD_W-1:0] pa_in [6], pb_in [6], pa_ff [6], pb_ff [6];
   logic                     t2_valid_ff;

   always_comb begin
      pa_in[0] = PROD_W'(b2_ff[1]) * PROD_W'(b1_ff[2]);
      pb_in[0] = PROD_W'(b2_ff[2]) * PROD_W'(b1_ff[1]);
      pa_in[1] = PROD_W'(b2_ff[2]) * PROD_W'(b1_ff[0]);
      pb_in[1] = PROD_W'(b2_ff[0]) * PROD_W'(b1_ff[2]);
      pa_in[2] = PROD_W'(b2_ff[0]) * PROD_W'(b1_ff[1]);
      pb_in[2] = PROD_W'(b2_ff[1]) * PROD_W'(b1_ff[0]);
      pa_in[3] = PROD_W'(b3_ff[1]) * PROD_W'(b2_ff[2]);
      pb_in[3] = PROD_W'(b3_ff[2]) * PROD_W'(b2_ff[1]);
      pa_in[4] = PROD_W'(b3_ff[2]) * PROD_W'(b2_ff[0]);
      pb_in[4] = PROD_W'(b3_ff[0]) * PROD_W'(b2_ff[2]);
      pa_in[5] = PROD_W'(b3_ff[0]) * PROD_W'(b2_ff[1]);
      pb_in[5] = PROD_W'(b3_ff[1]) * PROD_W'(b2_ff[0]);
   end

   logic [2:0][CROSS_W-1:0] n1_in, n2_in, n1_ff, n2_ff;
   logic                    t3_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_in[i] = CROSS_W'(pa_ff[i])   - CROSS_W'(pb_ff[i]);
         n2_in[i] = CROSS_W'(pa_ff[i+3]) - CROSS_W'(pb_ff[i+3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
      end else if (ce) begin
         t1_valid_ff <= req_tvalid;
         t2_valid_ff <= t1_valid_ff;
         t3_valid_ff <= t2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         b3_ff <= b3_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         n1_ff <= n1_in;
         n2_ff <= n2_in;
      end
   end

   // ------------------------------------------------------ unit normals
   unit_out_type unit1, unit2;

   dau_unit_norm u_norm1 (
      .clock     (clock),
      .reset     (reset),
      .enable    (ce),
      .in_valid  (t3_valid_ff),
      .in_normal (n1_ff),
      .out_unit  (unit1)
   );

   dau_unit_norm u_norm2 (
      .clock     (clock),
      .reset     (reset),
      .enable    (ce),
      .in_valid  (t3_valid_ff),
      .in_normal (n2_ff),
      .out_unit  (unit2)
   );

   // ------------------------------------------------------------ cosine
   logic signed [DOTP_W-1:0] dp_in [3], dp_ff [3];
   logic                     d1_valid_ff, d1_deg_ff;
   logic signed [DOTP_W-1:0] dsum, cfull;
   logic signed [C_W-1:0]    c_in, c_ff;
   logic                     d2_valid_ff, d2_deg_ff;
   logic [DOTP_W-1:0]        csq_in;
   logic [ROOT_W-1:0]        csq_ff;
   logic signed [C_W-1:0]    c3_ff;
   logic                     d3_valid_ff, d3_deg_ff;
   logic [ROOT_W-1:0]        tsq_in, tsq_ff;
   logic signed [C_W-1:0]    c4_ff;
   logic                     d4_valid_ff, d4_deg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp_in[i] = DOTP_W'($signed(unit1.u[i])) * DOTP_W'($signed(unit2.u[i]));
      end
      dsum  = dp_ff[0] + dp_ff[1] + dp_ff[2] + DOTP_W'(64'd1 << (UNIT_BITS - 1));
      cfull = dsum >>> UNIT_BITS;
      // clamp the cosine into [-1, 1]
      if (cfull > C_LIM) begin
         c_in = C_W'(C_LIM);
      end else if (cfull < -C_LIM) begin
         c_in = -C_W'(C_LIM);
      end else begin
         c_in = C_W'(cfull);
      end
      csq_in = DOTP_W'(c_ff) * DOTP_W'(c_ff);
      tsq_in = ROOT_W'(64'd1 << (2 * UNIT_BITS)) - csq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
         d3_valid_ff <= 1'b0;
         d4_valid_ff <= 1'b0;
      end else if (ce) begin
         d1_valid_ff <= unit1.valid;
         d2_valid_ff <= d1_valid_ff;
         d3_valid_ff <= d2_valid_ff;
         d4_valid_ff <= d3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dp_ff     <= dp_in;
         d1_deg_ff <= unit1.zero | unit2.zero;
         c_ff      <= c_in;
         d2_deg_ff <= d1_deg_ff;
         csq_ff    <= csq_in[ROOT_W-1:0];
         c3_ff     <= c_ff;
         d3_deg_ff <= d2_deg_ff;
         tsq_ff    <= tsq_in;
         c4_ff     <= c3_ff;
         d4_deg_ff <= d3_deg_ff;
      end
   end

   // ------------------------------------------- sine: t = sqrt(1 - c^2)
   logic              st_valid [SQRT_STEPS+1];
   logic [ROOT_W-1:0] st_rem   [SQRT_STEPS+1];
   logic [ROOT_W-1:0] st_root  [SQRT_STEPS+1];
   logic [CTAG_W-1:0] st_tag   [SQRT_STEPS+1];

   assign st_valid[0] = d4_valid_ff;
   assign st_rem[0]   = tsq_ff;
   assign st_root[0]  = '0;
   assign st_tag[0]   = {d4_deg_ff, c4_ff};

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sine
      dau_sqrt_cell #(.STEP(k), .TAG_W(CTAG_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (ce),
         .in_valid  (st_valid[k]),
         .in_rem    (st_rem[k]),
         .in_root   (st_root[k]),
         .in_tag    (st_tag[k]),
         .out_valid (st_valid[k+1]),
         .out_rem   (st_rem[k+1]),
         .out_root  (st_root[k+1]),
         .out_tag   (st_tag[k+1])
      );
   end

   // --------------------------------------------- CORDIC start vector
   // c < 0: start from (t, -c) at pi/2, else from (c, t) at zero
   logic signed [C_W-1:0]  cs;
   logic signed [XY_W-1:0] t_ext, c_ext;
   logic signed [XY_W-1:0] x0_in, y0_in, x0_ff, y0_ff;
   logic signed [Z_W-1:0]  z0_in, z0_ff;
   logic                   c0_valid_ff, c0_deg_ff;

   always_comb begin
      cs    = st_tag[SQRT_STEPS][C_W-1:0];
      t_ext = XY_W'(st_root[SQRT_STEPS][QUO_W-1:0]);
      c_ext = XY_W'(cs);
      if (cs < 0) begin
         x0_in = t_ext;
         y0_in = -c_ext;
         z0_in = Z_W'(HALF_PI60);
      end else begin
         x0_in = c_ext;
         y0_in = t_ext;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_valid_ff <= 1'b0;
      end else if (ce) begin
         c0_valid_ff <= st_valid[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         x0_ff     <= x0_in;
         y0_ff     <= y0_in;
         z0_ff     <= z0_in;
         c0_deg_ff <= st_tag[SQRT_STEPS][CTAG_W-1];
      end
   end

   // ------------------------------------------------------ CORDIC chain
   logic                   cr_valid [CORDIC_STEPS+1];
   logic signed [XY_W-1:0] cr_x     [CORDIC_STEPS+1];
   logic signed [XY_W-1:0] cr_y     [CORDIC_STEPS+1];
   logic signed [Z_W-1:0]  cr_z     [CORDIC_STEPS+1];
   logic                   cr_tag   [CORDIC_STEPS+1];

   assign cr_valid[0] = c0_valid_ff;
   assign cr_x[0]     = x0_ff;
   assign cr_y[0]     = y0_ff;
   assign cr_z[0]     = z0_ff;
   assign cr_tag[0]   = c0_deg_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      dau_cordic_cell #(.STEP(k), .TAG_W(1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (ce),
         .in_valid  (cr_valid[k]),
         .in_x      (cr_x[k]),
         .in_y      (cr_y[k]),
         .in_z      (cr_z[k]),
         .in_tag    (cr_tag[k]),
         .out_valid (cr_valid[k+1]),
         .out_x     (cr_x[k+1]),
         .out_y     (cr_y[k+1]),
         .out_z     (cr_z[k+1]),
         .out_tag   (cr_tag[k+1])
      );
   end

   // ------------------------------------------ rounding to output format
   logic signed [Z_W-1:0] zpos;
   logic [63:0]           arnd;
   logic [ANGLE_W-1:0]    angle_in, angle_ff;
   logic                  deg_ff;
   logic                  last_v_ff;

   always_comb begin
      zpos = (cr_z[CORDIC_STEPS] < 0) ? '0 : cr_z[CORDIC_STEPS];
      arnd = (64'(zpos) + HALF) >> SHIFT;
      if (arnd > AMAX) arnd = AMAX;
      angle_in = cr_tag[CORDIC_STEPS] ? '0 : arnd[ANGLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_v_ff <= 1'b0;
      end else if (ce) begin
         last_v_ff <= cr_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         angle_ff <= angle_in;
         deg_ff   <= cr_tag[CORDIC_STEPS];
      end
   end

   // --------------------------------------------- output reg + skid slot
   logic               push, pop, load_out;
   logic               out_v_ff;
   logic [ANGLE_W-1:0] out_angle_ff, skid_angle_ff;
   logic               out_deg_ff, skid_deg_ff;

   assign push     = ce & last_v_ff;
   assign pop      = out_v_ff & rsp_tready;
   assign load_out = ~out_v_ff | pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (load_out) begin
         out_v_ff  <= skid_v_ff | push;
         skid_v_ff <= 1'b0;
      end else if (push) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_angle_ff <= skid_v_ff ? skid_angle_ff : angle_ff;
         out_deg_ff   <= skid_v_ff ? skid_deg_ff   : deg_ff;
      end else if (push) begin
         skid_angle_ff <= angle_ff;
         skid_deg_ff   <= deg_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RSP_W'(out_angle_ff);
   assign rsp_tuser  = out_deg_ff;

   // ---------------------------------------------------------- checks
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid slot holds a word while output register is empty");

   a_skid_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid slot filled without a stalled output");

   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (out_angle_ff == '0))
      else $error("degenerate word carries a nonzero angle");

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (64'(out_angle_ff) <= AMAX))
      else $error("angle above pi");

endmodule

/* src/dau_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_sqrt_cell: one step of the bit-pair integer square root
// Resolves one root bit per cell; remainder and partial root move on.
// ----------------------------------------------------------------------------
module dau_sqrt_cell #(
   parameter int STEP  = 0,
   parameter int TAG_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [dau_pkg::ROOT_W-1:0]  in_rem,
   input  logic [dau_pkg::ROOT_W-1:0]  in_root,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [dau_pkg::ROOT_W-1:0]  out_rem,
   output logic [dau_pkg::ROOT_W-1:0]  out_root,
   output logic [TAG_W-1:0]            out_tag
);
   import dau_pkg::*;

   localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

   logic [ROOT_W-1:0] trial;
   logic [ROOT_W-1:0] rem_in, rem_ff;
   logic [ROOT_W-1:0] root_in, root_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              valid_ff;

   always_comb begin
      trial = in_root + BIT;
      if (in_rem >= trial) begin
         rem_in  = in_rem - trial;
         root_in = (in_root >> 1) + BIT;
      end else begin
         rem_in  = in_rem;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_tag   = tag_ff;

endmodule

/* src/dau_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_div_cell: one restoring division step on three lanes
// Three components share one divisor; one quotient bit per cell.
// ----------------------------------------------------------------------------
module dau_div_cell #(
   parameter int STEP  = 0,
   parameter int TAG_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  logic [2:0][dau_pkg::DREM_W-1:0]  in_rem,
   input  logic [2:0][dau_pkg::QUO_W-1:0]   in_quo,
   input  logic [dau_pkg::QUO_W-1:0]        in_div,
   input  logic [TAG_W-1:0]                 in_tag,
   output logic                             out_valid,
   output logic [2:0][dau_pkg::DREM_W-1:0]  out_rem,
   output logic [2:0][dau_pkg::QUO_W-1:0]   out_quo,
   output logic [dau_pkg::QUO_W-1:0]        out_div,
   output logic [TAG_W-1:0]                 out_tag
);
   import dau_pkg::*;

   localparam int QBIT = QUO_W - 1 - STEP;

   logic [2:0][DREM_W-1:0] rem_in, rem_ff;
   logic [2:0][QUO_W-1:0]  quo_in, quo_ff;
   logic [DREM_W-1:0]      diff;
   logic [QUO_W-1:0]       div_ff;
   logic [TAG_W-1:0]       tag_ff;
   logic                   valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo_in[i] = in_quo[i];
         diff      = in_rem[i];
         if (in_rem[i] >= DREM_W'(in_div)) begin
            diff            = in_rem[i] - DREM_W'(in_div);
            quo_in[i][QBIT] = 1'b1;
         end
         rem_in[i] = diff << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         div_ff <= in_div;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;
   assign out_tag   = tag_ff;

endmodule

/* src/dau_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates (x, y) toward the x axis and accumulates the angle in Q.60.
// ----------------------------------------------------------------------------
module dau_cordic_cell #(
   parameter int STEP  = 0,
   parameter int TAG_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             enable,
   input  logic                             in_valid,
   input  logic signed [dau_pkg::XY_W-1:0]  in_x,
   input  logic signed [dau_pkg::XY_W-1:0]  in_y,
   input  logic signed [dau_pkg::Z_W-1:0]   in_z,
   input  logic [TAG_W-1:0]                 in_tag,
   output logic                             out_valid,
   output logic signed [dau_pkg::XY_W-1:0]  out_x,
   output logic signed [dau_pkg::XY_W-1:0]  out_y,
   output logic signed [dau_pkg::Z_W-1:0]   out_z,
   output logic [TAG_W-1:0]                 out_tag
);
   import dau_pkg::*;

   localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q60(STEP));

   logic signed [XY_W-1:0] dx, dy;
   logic signed [XY_W-1:0] x_in, x_ff, y_in, y_ff;
   logic signed [Z_W-1:0]  z_in, z_ff;
   logic [TAG_W-1:0]       tag_ff;
   logic                   valid_ff;

   always_comb begin
      dx = in_y >>> STEP;
      dy = in_x >>> STEP;
      if (in_y > 0) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_tag   = tag_ff;

endmodule

/* src/dau_unit_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dau_unit_norm: plane normal to Q.30 unit vector
// Normalize to 30 bits, sum of squares, root chain, divide chain.
// ----------------------------------------------------------------------------
module dau_unit_norm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  logic [2:0][dau_pkg::CROSS_W-1:0]  in_normal,
   output dau_pkg::unit_out_type             out_unit
);
   import dau_pkg::*;

   localparam int TAG_W  = 1 + 3 + 3 * SM_W;
   localparam int DTAG_W = 4;

   // stage 1: sign / magnitude
   logic                  p1_valid_ff;
   logic [2:0]            p1_neg_ff;
   logic [2:0][MAG_W-1:0] p1_mag_ff, mag_in;
   logic [MAG_W-1:0]      p1_or_ff, or_in;

   always_comb begin
      or_in = '0;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = in_normal[i][CROSS_W-1] ? (~in_normal[i] + MAG_W'(1)) : in_normal[i];
         or_in     = or_in | mag_in[i];
      end
   end

   // stage 2: per-byte bit length
   logic                   p2_valid_ff;
   logic [2:0]             p2_neg_ff;
   logic [2:0][MAG_W-1:0]  p2_mag_ff;
   logic [CHUNKS-1:0]      p2_nz_ff, nz_in;
   logic [CHUNKS-1:0][3:0] p2_clen_ff, clen_in;
   logic [CHUNKS*8-1:0]    or_pad;

   always_comb begin
      or_pad = {(CHUNKS * 8 - MAG_W)'(0), p1_or_ff};
      for (int g = 0; g < CHUNKS; g++) begin
         nz_in[g]   = |or_pad[8*g +: 8];
         clen_in[g] = 4'd0;
         for (int b = 0; b < 8; b++) begin
            if (or_pad[8*g + b]) clen_in[g] = 4'(b + 1);
         end
      end
   end

   // stage 3: bit length of the largest magnitude
   logic                  p3_valid_ff;
   logic [2:0]            p3_neg_ff;
   logic [2:0][MAG_W-1:0] p3_mag_ff;
   logic [LEN_W-1:0]      p3_len_ff, len_in;
   logic                  p3_zero_ff;

   always_comb begin
      len_in = '0;
      for (int g = 0; g < CHUNKS; g++) begin
         if (p2_nz_ff[g]) len_in = LEN_W'(8 * g) + LEN_W'(p2_clen_ff[g]);
      end
   end

   // stage 4: coarse shift by whole bytes
   logic                   p4_valid_ff;
   logic [2:0]             p4_neg_ff;
   logic [2:0][WIDE_W-1:0] p4_wide_ff, wide_in;
   logic [2:0]             p4_fine_ff;
   logic                   p4_zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wide_in[i] = {p3_mag_ff[i], UNIT_BITS'(0)} >> {p3_len_ff[LEN_W-1:3], 3'b000};
      end
   end

   // stage 5: fine shift
   logic                 p5_valid_ff;
   logic [2:0]           p5_neg_ff;
   logic [2:0][SM_W-1:0] p5_sm_ff, sm_in;
   logic                 p5_zero_ff;
   logic [WIDE_W-1:0]    fine;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fine     = p4_wide_ff[i] >> p4_fine_ff;
         sm_in[i] = fine[SM_W-1:0];
      end
   end

   // stage 6: squares
   logic                 p6_valid_ff;
   logic [2:0]           p6_neg_ff;
   logic [2:0][SM_W-1:0] p6_sm_ff;
   logic [2:0][SQ_W-1:0] p6_sq_ff, sq_in;
   logic                 p6_zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(p5_sm_ff[i]) * SQ_W'(p5_sm_ff[i]);
      end
   end

   // stage 7: sum of squares
   logic                 p7_valid_ff;
   logic [2:0]           p7_neg_ff;
   logic [2:0][SM_W-1:0] p7_sm_ff;
   logic [ROOT_W-1:0]    p7_sum_ff, sum_in;
   logic                 p7_zero_ff;

   assign sum_in = ROOT_W'(p6_sq_ff[0]) + ROOT_W'(p6_sq_ff[1]) + ROOT_W'(p6_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
         p7_valid_ff <= 1'b0;
      end else if (enable) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
         p6_valid_ff <= p5_valid_ff;
         p7_valid_ff <= p6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p1_neg_ff  <= {in_normal[2][CROSS_W-1], in_normal[1][CROSS_W-1],
                        in_normal[0][CROSS_W-1]};
         p1_mag_ff  <= mag_in;
         p1_or_ff   <= or_in;
         p2_neg_ff  <= p1_neg_ff;
         p2_mag_ff  <= p1_mag_ff;
         p2_nz_ff   <= nz_in;
         p2_clen_ff <= clen_in;
         p3_neg_ff  <= p2_neg_ff;
         p3_mag_ff  <= p2_mag_ff;
         p3_len_ff  <= len_in;
         p3_zero_ff <= ~|p2_nz_ff;
         p4_neg_ff  <= p3_neg_ff;
         p4_wide_ff <= wide_in;
         p4_fine_ff <= p3_len_ff[2:0];
         p4_zero_ff <= p3_zero_ff;
         p5_neg_ff  <= p4_neg_ff;
         p5_sm_ff   <= sm_in;
         p5_zero_ff <= p4_zero_ff;
         p6_neg_ff  <= p5_neg_ff;
         p6_sm_ff   <= p5_sm_ff;
         p6_sq_ff   <= sq_in;
         p6_zero_ff <= p5_zero_ff;
         p7_neg_ff  <= p6_neg_ff;
         p7_sm_ff   <= p6_sm_ff;
         p7_sum_ff  <= sum_in;
         p7_zero_ff <= p6_zero_ff;
      end
   end

   // root chain: s = floor(sqrt(sum))
   logic              sq_valid [SQRT_STEPS+1];
   logic [ROOT_W-1:0] sq_rem   [SQRT_STEPS+1];
   logic [ROOT_W-1:0] sq_root  [SQRT_STEPS+1];
   logic [TAG_W-1:0]  sq_tag   [SQRT_STEPS+1];

   assign sq_valid[0] = p7_valid_ff;
   assign sq_rem[0]   = p7_sum_ff;
   assign sq_root[0]  = '0;
   assign sq_tag[0]   = {p7_zero_ff, p7_neg_ff, p7_sm_ff};

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
      dau_sqrt_cell #(.STEP(k), .TAG_W(TAG_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (sq_valid[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_tag    (sq_tag[k]),
         .out_valid (sq_valid[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_tag   (sq_tag[k+1])
      );
   end

   // divide chain: q = sm * 2^30 / s
   logic                   dv_valid [DIV_STEPS+1];
   logic [2:0][DREM_W-1:0] dv_rem   [DIV_STEPS+1];
   logic [2:0][QUO_W-1:0]  dv_quo   [DIV_STEPS+1];
   logic [QUO_W-1:0]       dv_div   [DIV_STEPS+1];
   logic [DTAG_W-1:0]      dv_tag   [DIV_STEPS+1];
   logic [2:0][SM_W-1:0]   root_sm;

   assign root_sm     = sq_tag[SQRT_STEPS][3*SM_W-1:0];
   assign dv_valid[0] = sq_valid[SQRT_STEPS];
   assign dv_quo[0]   = '0;
   assign dv_div[0]   = sq_root[SQRT_STEPS][QUO_W-1:0];
   assign dv_tag[0]   = sq_tag[SQRT_STEPS][TAG_W-1 -: DTAG_W];

   always_comb begin
      for (int i = 0; i < 3; i++) dv_rem[0][i] = DREM_W'(root_sm[i]);
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      dau_div_cell #(.STEP(k), .TAG_W(DTAG_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (dv_valid[k]),
         .in_rem    (dv_rem[k]),
         .in_quo    (dv_quo[k]),
         .in_div    (dv_div[k]),
         .in_tag    (dv_tag[k]),
         .out_valid (dv_valid[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_quo   (dv_quo[k+1]),
         .out_div   (dv_div[k+1]),
         .out_tag   (dv_tag[k+1])
      );
   end

   // apply signs
   unit_out_type out_in, out_ff;
   logic [DTAG_W-1:0] last_tag;
   logic [U_W-1:0]    qext;

   assign last_tag = dv_tag[DIV_STEPS];

   always_comb begin
      out_in.valid = dv_valid[DIV_STEPS];
      out_in.zero  = last_tag[3];
      for (int i = 0; i < 3; i++) begin
         qext        = U_W'(dv_quo[DIV_STEPS][i]);
         out_in.u[i] = last_tag[i] ? (~qext + U_W'(1)) : qext;
      end
   end

   // one process owns the whole output struct
   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff.zero <= out_in.zero;
         out_ff.u    <= out_in.u;
      end
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff.valid <= out_in.valid;
      end
   end

   assign out_unit = out_ff;

endmodule
